FILE: rtl/pfr_pkg.sv
// Shared types and codes for the packet field reader.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package pfr_pkg;

    // Operation codes
    typedef enum logic [1:0] {
        OP_LOAD        = 2'd0,
        OP_READ_INT    = 2'd1,
        OP_READ_STR    = 2'd2,
        OP_READ_PACKED = 2'd3
    } pfr_op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_END     = 3'd1,
        ST_TRUNC   = 3'd2,
        ST_BADSIZE = 3'd3,
        ST_FULL    = 3'd4
    } pfr_status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } pfr_state_t;

    localparam logic [7:0] VARINT_MASK = 8'h7f;

    // One command transaction as seen by the engine
    typedef struct packed {
        pfr_op_t    operation;
        logic [7:0] data_byte;
        logic       first_byte;
        logic [2:0] int_size;
        logic       network_order;
    } pfr_item_t;

    // One result transaction
    typedef struct packed {
        logic [31:0] value;
        logic [11:0] string_start;
        logic [11:0] string_length;
        pfr_status_t status;
        logic [12:0] read_position;
    } pfr_result_t;

endpackage

FILE: rtl/pfr_channels.sv
// Valid/ready channel interfaces for the packet field reader.
// Command channel and response channel; no package dependency.
`timescale 1ns / 1ps

interface pfr_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       first_byte;
    logic [2:0] int_size;
    logic       network_order;

    modport source (output valid, output operation, output data_byte,
                    output first_byte, output int_size, output network_order,
                    input ready);
    modport sink   (input valid, input operation, input data_byte,
                    input first_byte, input int_size, input network_order,
                    output ready);
endinterface

interface pfr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [11:0] string_start;
    logic [11:0] string_length;
    logic [2:0]  status;
    logic [12:0] read_position;

    modport source (output valid, output value, output string_start,
                    output string_length, output status, output read_position,
                    input ready);
    modport sink   (input valid, input value, input string_start,
                    input string_length, input status, input read_position,
                    output ready);
endinterface

FILE: rtl/pfr_engine.sv
// Packet field reader engine: byte store, length/offset state and scan sequencer.
// Depends on pfr_pkg.
`timescale 1ns / 1ps

module pfr_engine #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  pfr_pkg::pfr_item_t  item,
    output logic                item_ready,
    output logic                res_valid,
    output pfr_pkg::pfr_result_t res,
    input  logic                res_ready
);
    import pfr_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam logic [CW-1:0] BUF_LEN = CW'(BUFFER_BYTES);

    pfr_state_t    state_reg, state_next;
    pfr_op_t       op_reg, op_next;
    logic [2:0]    size_reg, size_next;
    logic          big_reg, big_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] offset_reg, offset_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] scan_addr_reg, scan_addr_next;
    logic [31:0]   acc_reg, acc_next;
    pfr_result_t   res_reg, res_next;

    // byte store
    logic [7:0]    mem [BUFFER_BYTES];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [CW-1:0] eff_len;

    logic          accept;
    logic [CW-1:0] remaining_now;
    logic          size_ok;
    logic          pre_done;
    logic [31:0]   int_acc_next;
    logic [31:0]   pk_acc_next;
    logic          rem_last;
    logic          int_last;
    logic          scan_done;

    assign item_ready    = (state_reg == S_IDLE);
    assign accept        = item_valid && item_ready;
    assign res_valid     = (state_reg == S_DONE);
    assign res           = res_reg;
    assign remaining_now = len_reg - offset_reg;
    assign eff_len       = item.first_byte ? '0 : len_reg;
    assign wr_en         = accept && (item.operation == OP_LOAD) && (eff_len < BUF_LEN);
    assign rd_addr       = (state_reg == S_IDLE) ? offset_reg[AW-1:0]
                                                 : scan_addr_reg[AW-1:0];

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[eff_len[AW-1:0]] <= item.data_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // accept-time checks
    always_comb
    begin
        size_ok  = (item.int_size == 3'd1) || (item.int_size == 3'd2) ||
                   (item.int_size == 3'd4);
        pre_done = 1'b1;
        case (item.operation)
            OP_LOAD:     pre_done = 1'b1;
            OP_READ_INT: pre_done = !size_ok || (CW'(item.int_size) > remaining_now);
            default:     pre_done = (remaining_now == '0);
        endcase
    end

    // per-byte scan step on the byte fetched last cycle
    always_comb
    begin
        int_acc_next = big_reg ? {acc_reg[23:0], rd_data_reg}
                               : acc_reg | (32'(rd_data_reg) << {cnt_reg[1:0], 3'b000});
        pk_acc_next  = {acc_reg[24:0], rd_data_reg[6:0] & VARINT_MASK[6:0]};
        rem_last     = (cnt_reg == rem_reg - CW'(1));
        int_last     = (cnt_reg == CW'(size_reg - 3'd1));
        case (op_reg)
            OP_READ_INT:    scan_done = int_last;
            OP_READ_STR:    scan_done = (rd_data_reg == 8'h00) || rem_last;
            OP_READ_PACKED: scan_done = !rd_data_reg[7] || rem_last;
            default:        scan_done = 1'b1;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = pre_done ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        logic [CW-1:0] pos_new;
        op_next        = op_reg;
        size_next      = size_reg;
        big_next       = big_reg;
        len_next       = len_reg;
        offset_next    = offset_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        scan_addr_next = scan_addr_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        pos_new        = offset_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = item.operation;
                    size_next      = item.int_size;
                    big_next       = item.network_order;
                    rem_next       = remaining_now;
                    cnt_next       = '0;
                    scan_addr_next = offset_reg + CW'(1);
                    acc_next       = '0;
                    res_next       = '0;
                    res_next.status = ST_OK;
                    case (item.operation)
                        OP_LOAD:
                        begin
                            if (item.first_byte)
                            begin
                                pos_new = '0;
                            end
                            len_next = wr_en ? eff_len + CW'(1) : eff_len;
                            if (!wr_en)
                            begin
                                res_next.status = ST_FULL;
                            end
                        end
                        OP_READ_INT:
                        begin
                            if (!size_ok)
                            begin
                                res_next.status = ST_BADSIZE;
                            end
                            else if (CW'(item.int_size) > remaining_now)
                            begin
                                res_next.status = (remaining_now == '0) ? ST_END : ST_TRUNC;
                            end
                        end
                        default:
                        begin
                            if (remaining_now == '0)
                            begin
                                res_next.status = ST_END;
                            end
                        end
                    endcase
                    offset_next            = pos_new;
                    res_next.read_position = 13'(pos_new);
                end
            end
            S_SCAN:
            begin
                cnt_next       = cnt_reg + CW'(1);
                scan_addr_next = scan_addr_reg + CW'(1);
                acc_next       = (op_reg == OP_READ_INT) ? int_acc_next : pk_acc_next;
                if (scan_done)
                begin
                    case (op_reg)
                        OP_READ_INT:
                        begin
                            res_next.value = (size_reg == 3'd1)
                                ? {{24{rd_data_reg[7]}}, rd_data_reg} : int_acc_next;
                            pos_new = offset_reg + CW'(size_reg);
                        end
                        OP_READ_STR:
                        begin
                            if (rd_data_reg == 8'h00)
                            begin
                                res_next.string_start  = 12'(offset_reg);
                                res_next.string_length = 12'(cnt_reg);
                                pos_new = offset_reg + cnt_reg + CW'(1);
                            end
                            else
                            begin
                                res_next.status = ST_TRUNC;
                                pos_new = len_reg;
                            end
                        end
                        default:
                        begin
                            if (!rd_data_reg[7])
                            begin
                                res_next.value = pk_acc_next;
                                pos_new = offset_reg + cnt_reg + CW'(1);
                            end
                            else
                            begin
                                res_next.status = ST_TRUNC;
                                pos_new = len_reg;
                            end
                        end
                    endcase
                    offset_next            = pos_new;
                    res_next.read_position = 13'(pos_new);
                end
            end
            S_DONE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            offset_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            offset_reg <= offset_next;
        end
    end

    // per-transaction working registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        size_reg      <= size_next;
        big_reg       <= big_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        scan_addr_reg <= scan_addr_next;
        acc_reg       <= acc_next;
        res_reg       <= res_next;
    end

    // read position never runs past the loaded length
    assert property (@(posedge clk) disable iff (!rst_n) offset_reg <= len_reg)
        else $error("read offset beyond packet length");

    // loaded length bounded by store size
    assert property (@(posedge clk) disable iff (!rst_n) len_reg <= BUF_LEN)
        else $error("packet length beyond store size");

    // a scan never looks past the bytes that remained at its start
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_SCAN) |-> (cnt_reg < rem_reg))
        else $error("scan ran past remaining bytes");

endmodule

FILE: rtl/packet_field_reader_unit.sv
// Top level of the packet field reader: command/response channels and result register.
// Depends on pfr_pkg, pfr_channels and pfr_engine.
`timescale 1ns / 1ps

// Usage
//   cmd carries one operation per transaction: load a byte, read an integer,
//   read a NUL-terminated string or read a packed 7-bit varint; the reads start
//   at the running read position. rsp returns exactly one result per command, in order.
//   A load, or a read that fails its accept-time checks (bad integer size,
//   too few bytes left, end of packet), gives its result without a scan;
//   other reads scan from the read position to the last integer byte, the
//   terminator, or the end of the packet.
//   The scan reads the byte store one byte per cycle through its single
//   registered read port; one command is in flight at a time, so a new command
//   is taken the cycle after the previous result moves to the response register.
//   The response register lets the engine finish and take the next command
//   while an earlier result waits; if rsp stays stalled, the engine holds its
//   finished result and cmd.ready drops until the register frees.
//   Reset clears packet length, read position and the pending response.
//   The byte store is not cleared; reads only reach bytes loaded since the
//   last packet restart.

module packet_field_reader_unit #(
    parameter int BUFFER_BYTES = 4096
) (
    input logic      clk,
    input logic      rst_n,
    pfr_cmd_if.sink  cmd,
    pfr_rsp_if.source rsp
);
    import pfr_pkg::*;

    pfr_item_t   item;
    logic        item_ready;
    logic        res_valid;
    pfr_result_t res;
    logic        res_ready;

    logic        out_valid_reg, out_valid_next;
    pfr_result_t out_reg, out_next;

    // command transaction to engine item
    always_comb
    begin
        item.operation     = pfr_op_t'(cmd.operation);
        item.data_byte     = cmd.data_byte;
        item.first_byte    = cmd.first_byte;
        item.int_size      = cmd.int_size;
        item.network_order = cmd.network_order;
    end

    assign cmd.ready = item_ready;

    pfr_engine #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (cmd.valid),
        .item       (item),
        .item_ready (item_ready),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    // response register
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.value         = out_reg.value;
    assign rsp.string_start  = out_reg.string_start;
    assign rsp.string_length = out_reg.string_length;
    assign rsp.status        = out_reg.status;
    assign rsp.read_position = out_reg.read_position;

endmodule
